[rtl/xfcu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package xfcu_pkg;

  typedef enum logic [3:0] {
    FN_STC    = 4'd0,
    FN_CLC    = 4'd1,
    FN_CMC    = 4'd2,
    FN_CLD    = 4'd3,
    FN_STD    = 4'd4,
    FN_LAHF   = 4'd5,
    FN_SAHF   = 4'd6,
    FN_PUSHF  = 4'd7,
    FN_PUSHFD = 4'd8,
    FN_POPF   = 4'd9,
    FN_POPFD  = 4'd10,
    FN_STI    = 4'd11,
    FN_CLI    = 4'd12
  } func_t;

  localparam int FLAG_W = 22;

  localparam logic [FLAG_W-1:0] F_CF    = 22'h000001;
  localparam logic [FLAG_W-1:0] F_BIT1  = 22'h000002;
  localparam logic [FLAG_W-1:0] F_IF    = 22'h000200;
  localparam logic [FLAG_W-1:0] F_DF    = 22'h000400;
  localparam logic [FLAG_W-1:0] F_IOPL  = 22'h003000;
  localparam logic [FLAG_W-1:0] F_RF    = 22'h010000;
  localparam logic [FLAG_W-1:0] F_VM    = 22'h020000;
  localparam logic [FLAG_W-1:0] F_VIF   = 22'h080000;
  localparam logic [FLAG_W-1:0] F_VIP   = 22'h100000;
  localparam logic [FLAG_W-1:0] F_SZAPC = 22'h0000D5;
  localparam logic [FLAG_W-1:0] F_ALW16 = 22'h004DD5;
  localparam logic [FLAG_W-1:0] F_ALW32 = 22'h244DD5 & 22'h3FFFFF;
  localparam logic [FLAG_W-1:0] F_ALL16 = 22'h007FD5;
  localparam logic [FLAG_W-1:0] F_ALL32 = 22'h3F7FD5;
  localparam logic [FLAG_W-1:0] F_RESET = F_BIT1;

  localparam logic [1:0] IOPL_MAX = 2'd3;

  // Input word, last field in the low bits.
  typedef struct packed {
    logic        user_level;
    logic [1:0]  cur_priv;
    logic        v86_mode;
    logic        prot_mode;
    logic [7:0]  ah_in;
    logic [31:0] pop_value;
    logic [3:0]  func;
  } item_t;

  // Result word, last field in the low bits.
  typedef struct packed {
    logic              one_step_shadow;
    logic              irq_recheck;
    logic              trap_pending;
    logic              fault_gp;
    logic              push_valid;
    logic [31:0]       push_value;
    logic              ah_valid;
    logic [7:0]        ah_out;
    logic [FLAG_W-1:0] flags_out;
  } res_t;

  localparam int IN_W  = $bits(item_t);
  localparam int RES_W = $bits(res_t);

endpackage
`default_nettype wire

[rtl/xfcu_exec.sv]
`timescale 1ns / 1ps
`default_nettype none
module xfcu_exec (
  input  wire xfcu_pkg::item_t                item,
  input  wire logic [xfcu_pkg::FLAG_W-1:0]    flag_reg,
  input  wire logic                           trap_reg,
  output xfcu_pkg::res_t                      res,
  output logic [xfcu_pkg::FLAG_W-1:0]         flag_next,
  output logic                                trap_next
);

  logic                        pm;
  logic                        vm;
  logic [1:0]                  iopl;
  logic                        popfd;
  logic [xfcu_pkg::FLAG_W-1:0] pop_val;
  logic [xfcu_pkg::FLAG_W-1:0] pop_mask;
  logic                        pop_fault;
  logic [xfcu_pkg::FLAG_W-1:0] pop_merged;

  assign pm    = item.prot_mode;
  assign vm    = item.prot_mode & item.v86_mode;
  assign iopl  = flag_reg[13:12];
  assign popfd = (item.func == xfcu_pkg::FN_POPFD);

  // POPF/POPFD write mask from the privilege checks
  always_comb begin
    pop_val   = popfd ? item.pop_value[xfcu_pkg::FLAG_W-1:0]
                      : {6'd0, item.pop_value[15:0]};
    pop_mask  = '0;
    pop_fault = 1'b0;
    if (!pm || (!vm && item.cur_priv == 2'd0)) begin
      pop_mask = xfcu_pkg::F_IF | xfcu_pkg::F_IOPL;
      if (popfd) begin
        pop_mask = pop_mask | xfcu_pkg::F_RF | xfcu_pkg::F_VIF | xfcu_pkg::F_VIP;
        pop_val  = pop_val & ~(xfcu_pkg::F_VIF | xfcu_pkg::F_VIP);
      end
    end else if (!vm) begin
      if (item.cur_priv <= iopl) begin
        pop_mask = xfcu_pkg::F_IF;
        if (popfd) begin
          pop_mask = pop_mask | xfcu_pkg::F_RF | xfcu_pkg::F_VIF | xfcu_pkg::F_VIP;
          pop_val  = pop_val & ~(xfcu_pkg::F_VIF | xfcu_pkg::F_VIP);
        end
      end
    end else if (iopl == xfcu_pkg::IOPL_MAX) begin
      pop_mask = xfcu_pkg::F_IF;
    end else begin
      pop_fault = 1'b1;
    end
    pop_mask   = pop_mask | (popfd ? xfcu_pkg::F_ALW32 : xfcu_pkg::F_ALW16);
    pop_merged = (flag_reg & ~pop_mask) | (pop_val & pop_mask);
  end

  always_comb begin
    flag_next = flag_reg;
    trap_next = trap_reg;
    res       = '0;
    unique case (item.func)
      xfcu_pkg::FN_STC: flag_next = flag_reg | xfcu_pkg::F_CF;
      xfcu_pkg::FN_CLC: flag_next = flag_reg & ~xfcu_pkg::F_CF;
      xfcu_pkg::FN_CMC: flag_next = flag_reg ^ xfcu_pkg::F_CF;
      xfcu_pkg::FN_CLD: flag_next = flag_reg & ~xfcu_pkg::F_DF;
      xfcu_pkg::FN_STD: flag_next = flag_reg | xfcu_pkg::F_DF;
      xfcu_pkg::FN_LAHF: begin
        res.ah_out   = flag_reg[7:0] & (xfcu_pkg::F_SZAPC[7:0] | xfcu_pkg::F_BIT1[7:0]);
        res.ah_out   = res.ah_out | xfcu_pkg::F_BIT1[7:0];
        res.ah_valid = 1'b1;
      end
      xfcu_pkg::FN_SAHF: begin
        flag_next = {flag_reg[xfcu_pkg::FLAG_W-1:8],
                     (item.ah_in & xfcu_pkg::F_SZAPC[7:0]) | xfcu_pkg::F_BIT1[7:0]};
      end
      xfcu_pkg::FN_PUSHF, xfcu_pkg::FN_PUSHFD: begin
        if (!vm || iopl == xfcu_pkg::IOPL_MAX) begin
          if (item.func == xfcu_pkg::FN_PUSHF) begin
            res.push_value = {10'd0, (flag_reg & xfcu_pkg::F_ALL16) | xfcu_pkg::F_BIT1};
          end else begin
            res.push_value = {10'd0, (flag_reg & xfcu_pkg::F_ALL32
                              & ~(xfcu_pkg::F_RF | xfcu_pkg::F_VM)) | xfcu_pkg::F_BIT1};
          end
          res.push_valid = 1'b1;
        end else begin
          res.fault_gp = 1'b1;
        end
      end
      xfcu_pkg::FN_POPF, xfcu_pkg::FN_POPFD: begin
        if (pop_fault) begin
          res.fault_gp = 1'b1;
        end else begin
          flag_next       = pop_merged;
          trap_next       = pop_merged[9] & pop_merged[8];
          res.irq_recheck = 1'b1;
        end
      end
      xfcu_pkg::FN_STI: begin
        if (!pm || (!vm && item.cur_priv <= iopl)
            || (vm && item.user_level && iopl == xfcu_pkg::IOPL_MAX)) begin
          flag_next           = flag_reg | xfcu_pkg::F_IF;
          trap_next           = flag_reg[8];
          res.irq_recheck     = 1'b1;
          res.one_step_shadow = 1'b1;
        end else if (!vm || iopl != xfcu_pkg::IOPL_MAX) begin
          res.fault_gp = 1'b1;
        end
      end
      xfcu_pkg::FN_CLI: begin
        if (!pm || (!vm && item.cur_priv <= iopl) || iopl == xfcu_pkg::IOPL_MAX) begin
          flag_next = flag_reg & ~xfcu_pkg::F_IF;
          trap_next = 1'b0;
        end else begin
          res.fault_gp = 1'b1;
        end
      end
      default: ;
    endcase
    res.flags_out    = flag_next;
    res.trap_pending = trap_next;
  end

endmodule
`default_nettype wire

[rtl/x86_flag_control_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// x86 flag-control execute unit.
// Input channel s_axis_*: one word per flag instruction (opcode, popped
// value, AH and the mode/privilege bits). Output channel m_axis_*: one
// result word per input word (new flags, AH or push image, fault and
// interrupt-control strobes).
// The EFLAGS image and the trap indicator live inside the unit and are
// updated at the edge the input word is accepted, so each word sees the
// flags left by the one before it.
// The result appears on m_axis_tvalid in the cycle after accept.
// Throughput: one word per cycle while results are taken; decode and merge
// are a single level of mask logic feeding the output register.
// When the receiver stalls, the output register holds its word and
// s_axis_tready drops until that word is taken; a word is accepted in the
// same cycle the held result leaves.
// Reset clears m_axis_tvalid and sets the flags to 0x2 (reserved
// bit one set), trap indicator clear.
module x86_flag_control_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // func[3:0], pop_value[35:4], ah_in[43:36], prot_mode[44], v86_mode[45],
  // cur_priv[47:46], user_level[48], zero fill
  input  wire logic [55:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // flags_out[21:0], ah_out[29:22], ah_valid[30], push_value[62:31],
  // push_valid[63], fault_gp[64], trap_pending[65], irq_recheck[66],
  // one_step_shadow[67], zero fill
  output logic [71:0]      m_axis_tdata
);

  xfcu_pkg::item_t               item;
  xfcu_pkg::res_t                exec_res;
  xfcu_pkg::res_t                res_q;
  logic [xfcu_pkg::FLAG_W-1:0]   flag_reg;
  logic [xfcu_pkg::FLAG_W-1:0]   flag_next;
  logic                          trap_reg;
  logic                          trap_next;
  logic                          in_fire;

  assign item          = s_axis_tdata[xfcu_pkg::IN_W-1:0];
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata  = {{(72 - xfcu_pkg::RES_W){1'b0}}, res_q};

  xfcu_exec u_exec (
    .item      (item),
    .flag_reg  (flag_reg),
    .trap_reg  (trap_reg),
    .res       (exec_res),
    .flag_next (flag_next),
    .trap_next (trap_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      flag_reg      <= xfcu_pkg::F_RESET;
      trap_reg      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (in_fire) begin
        flag_reg <= flag_next;
        trap_reg <= trap_next;
      end
      if (in_fire) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_q <= exec_res;
    end
  end

  a_fault_keeps_flags: assert property (@(posedge clk) disable iff (rst)
    in_fire && exec_res.fault_gp |=> flag_reg == $past(flag_reg)
                                      && trap_reg == $past(trap_reg))
    else $error("flags changed on a faulting instruction");

  a_trap_tracks_flags: assert property (@(posedge clk) disable iff (rst)
    trap_reg == (flag_reg[9] & flag_reg[8]))
    else $error("trap indicator out of step with IF and TF");

  a_bit1_set: assert property (@(posedge clk) disable iff (rst)
    flag_reg[1])
    else $error("reserved flag bit one cleared");

  a_shadow_sets_if: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && res_q.one_step_shadow |->
      res_q.irq_recheck && res_q.flags_out[9] && !res_q.fault_gp)
    else $error("STI shadow without IF set and recheck");

endmodule
`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 1ps
module tb;

  localparam logic [xfcu_pkg::FLAG_W-1:0] TF_MASK = 22'h000100;
  localparam logic [3:0] FN_NONE_A = 4'd13;
  localparam logic [3:0] FN_NONE_B = 4'd14;
  localparam logic [3:0] FN_NONE_C = 4'd15;
  localparam int N_RANDOM = 1950;

  class eflags_board;
    logic [xfcu_pkg::FLAG_W-1:0] flag_q;
    bit trap_q;
    xfcu_pkg::res_t pending_results[$];
    int err_cnt;

    function new();
      flag_q = xfcu_pkg::F_RESET;
      trap_q = 1'b0;
      err_cnt = 0;
    endfunction

    function bit trap_now();
      return (flag_q & (xfcu_pkg::F_IF | TF_MASK)) == (xfcu_pkg::F_IF | TF_MASK);
    endfunction

    // Execute one flag instruction on the shadow EFLAGS and build its result.
    function xfcu_pkg::res_t next_flags_result(xfcu_pkg::item_t it);
      xfcu_pkg::res_t r;
      logic [xfcu_pkg::FLAG_W-1:0] val, mask;
      logic [1:0] iopl;
      bit vm, popfd, ok;
      r = '0;
      vm = it.prot_mode && it.v86_mode;
      iopl = flag_q[13:12];
      popfd = (it.func == xfcu_pkg::FN_POPFD);
      case (it.func)
        xfcu_pkg::FN_STC: flag_q = flag_q | xfcu_pkg::F_CF;
        xfcu_pkg::FN_CLC: flag_q = flag_q & ~xfcu_pkg::F_CF;
        xfcu_pkg::FN_CMC: flag_q = flag_q ^ xfcu_pkg::F_CF;
        xfcu_pkg::FN_CLD: flag_q = flag_q & ~xfcu_pkg::F_DF;
        xfcu_pkg::FN_STD: flag_q = flag_q | xfcu_pkg::F_DF;
        xfcu_pkg::FN_LAHF: begin
          r.ah_out = 8'((flag_q & xfcu_pkg::F_SZAPC) | xfcu_pkg::F_BIT1);
          r.ah_valid = 1'b1;
        end
        xfcu_pkg::FN_SAHF: begin
          flag_q = (flag_q & ~22'hFF) | ({14'd0, it.ah_in} & xfcu_pkg::F_SZAPC)
                   | xfcu_pkg::F_BIT1;
        end
        xfcu_pkg::FN_PUSHF, xfcu_pkg::FN_PUSHFD: begin
          if (!vm || iopl == xfcu_pkg::IOPL_MAX) begin
            if (it.func == xfcu_pkg::FN_PUSHF)
              r.push_value = 32'((flag_q & xfcu_pkg::F_ALL16) | xfcu_pkg::F_BIT1);
            else
              r.push_value = 32'((flag_q & xfcu_pkg::F_ALL32
                                  & ~(xfcu_pkg::F_RF | xfcu_pkg::F_VM)) | xfcu_pkg::F_BIT1);
            r.push_valid = 1'b1;
          end else begin
            r.fault_gp = 1'b1;
          end
        end
        xfcu_pkg::FN_POPF, xfcu_pkg::FN_POPFD: begin
          val = popfd ? it.pop_value[xfcu_pkg::FLAG_W-1:0] : {6'd0, it.pop_value[15:0]};
          ok = 1'b1;
          mask = '0;
          if (!it.prot_mode || (!vm && it.cur_priv == 2'd0)) begin
            mask = xfcu_pkg::F_IF | xfcu_pkg::F_IOPL;
            if (popfd) begin
              mask = mask | xfcu_pkg::F_RF | xfcu_pkg::F_VIF | xfcu_pkg::F_VIP;
              val = val & ~(xfcu_pkg::F_VIF | xfcu_pkg::F_VIP);
            end
          end else if (!vm) begin
            if (it.cur_priv <= iopl) begin
              mask = xfcu_pkg::F_IF;
              if (popfd) begin
                mask = mask | xfcu_pkg::F_RF | xfcu_pkg::F_VIF | xfcu_pkg::F_VIP;
                val = val & ~(xfcu_pkg::F_VIF | xfcu_pkg::F_VIP);
              end
            end
          end else if (iopl == xfcu_pkg::IOPL_MAX) begin
            mask = xfcu_pkg::F_IF;
          end else begin
            ok = 1'b0;
          end
          if (ok) begin
            mask = mask | (popfd ? xfcu_pkg::F_ALW32 : xfcu_pkg::F_ALW16);
            flag_q = (flag_q & ~mask) | (val & mask);
            trap_q = trap_now();
            r.irq_recheck = 1'b1;
          end else begin
            r.fault_gp = 1'b1;
          end
        end
        xfcu_pkg::FN_STI: begin
          if (!it.prot_mode || (!vm && it.cur_priv <= iopl) ||
              (vm && it.user_level && iopl == xfcu_pkg::IOPL_MAX)) begin
            flag_q = flag_q | xfcu_pkg::F_IF;
            trap_q = trap_now();
            r.irq_recheck = 1'b1;
            r.one_step_shadow = 1'b1;
          end else if (!vm || iopl != xfcu_pkg::IOPL_MAX) begin
            r.fault_gp = 1'b1;
          end
        end
        xfcu_pkg::FN_CLI: begin
          if (!it.prot_mode || (!vm && it.cur_priv <= iopl) ||
              iopl == xfcu_pkg::IOPL_MAX) begin
            flag_q = flag_q & ~xfcu_pkg::F_IF;
            trap_q = 1'b0;
          end else begin
            r.fault_gp = 1'b1;
          end
        end
        default: ;
      endcase
      r.flags_out = flag_q;
      r.trap_pending = trap_q;
      return r;
    endfunction

    function void note_word(xfcu_pkg::item_t it);
      pending_results.push_back(next_flags_result(it));
    endfunction

    task report(string what, logic [63:0] exp_v, logic [63:0] got_v);
      $display("%0t mismatch %s: expected %0h got %0h", $realtime, what, exp_v, got_v);
      err_cnt++;
    endtask

    task check_word(logic [71:0] w);
      xfcu_pkg::res_t e, g;
      g = w[xfcu_pkg::RES_W-1:0];
      if (pending_results.size() == 0) begin
        report("unexpected word", 64'd0, 64'(w));
      end else begin
        e = pending_results.pop_front();
        if (g.flags_out !== e.flags_out)
          report("flags_out", 64'(e.flags_out), 64'(g.flags_out));
        if (g.ah_out !== e.ah_out) report("ah_out", 64'(e.ah_out), 64'(g.ah_out));
        if (g.ah_valid !== e.ah_valid)
          report("ah_valid", 64'(e.ah_valid), 64'(g.ah_valid));
        if (g.push_value !== e.push_value)
          report("push_value", 64'(e.push_value), 64'(g.push_value));
        if (g.push_valid !== e.push_valid)
          report("push_valid", 64'(e.push_valid), 64'(g.push_valid));
        if (g.fault_gp !== e.fault_gp)
          report("fault_gp", 64'(e.fault_gp), 64'(g.fault_gp));
        if (g.trap_pending !== e.trap_pending)
          report("trap_pending", 64'(e.trap_pending), 64'(g.trap_pending));
        if (g.irq_recheck !== e.irq_recheck)
          report("irq_recheck", 64'(e.irq_recheck), 64'(g.irq_recheck));
        if (g.one_step_shadow !== e.one_step_shadow)
          report("one_step_shadow", 64'(e.one_step_shadow), 64'(g.one_step_shadow));
        if (w[71:xfcu_pkg::RES_W] !== '0)
          report("fill bits", 64'd0, 64'(w[71:xfcu_pkg::RES_W]));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;

  eflags_board board = new();
  bit quiet = 1'b0;
  int stall_left = 0;

  always #6 clk = ~clk;

  x86_flag_control_unit u_top (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // mostly short gaps, a few long ones, none during quiet stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic xfcu_pkg::item_t mk(logic [3:0] f, logic [31:0] pv, logic [7:0] ah,
                                         bit pm, bit v86, logic [1:0] cpl, bit user);
    xfcu_pkg::item_t it;
    it.func = f;
    it.pop_value = pv;
    it.ah_in = ah;
    it.prot_mode = pm;
    it.v86_mode = v86;
    it.cur_priv = cpl;
    it.user_level = user;
    return it;
  endfunction

  function automatic xfcu_pkg::item_t rand_item();
    xfcu_pkg::item_t it;
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) it.func = 4'($urandom_range(FN_NONE_A, FN_NONE_C));
    else if (r < 30)
      it.func = ($urandom_range(0, 1) != 0) ? xfcu_pkg::FN_POPF : xfcu_pkg::FN_POPFD;
    else it.func = 4'($urandom_range(xfcu_pkg::FN_STC, xfcu_pkg::FN_CLI));
    r = $urandom_range(0, 99);
    if (r < 3) it.pop_value = '0;
    else if (r < 6) it.pop_value = '1;
    else it.pop_value = $urandom();
    it.ah_in = 8'($urandom());
    it.prot_mode = 1'($urandom());
    it.v86_mode = 1'($urandom());
    it.cur_priv = 2'($urandom());
    it.user_level = 1'($urandom());
    return it;
  endfunction

  task automatic send_word(xfcu_pkg::item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(56 - xfcu_pkg::IN_W){1'b0}}, it};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_word(it);
  endtask

  task automatic run_directed();
    send_word(mk(xfcu_pkg::FN_STC, 32'h0, 8'h00, 1'b0, 1'b0, 2'd0, 1'b0));
    send_word(mk(xfcu_pkg::FN_CMC, 32'h0, 8'h00, 1'b0, 1'b0, 2'd0, 1'b0));
    // real mode whatever the VM86 bit says
    send_word(mk(xfcu_pkg::FN_CLC, 32'h0, 8'h00, 1'b0, 1'b1, 2'd3, 1'b1));
    send_word(mk(xfcu_pkg::FN_STD, 32'h0, 8'h00, 1'b0, 1'b0, 2'd0, 1'b0));
    send_word(mk(xfcu_pkg::FN_CLD, 32'h0, 8'h00, 1'b0, 1'b0, 2'd0, 1'b0));
    send_word(mk(xfcu_pkg::FN_SAHF, 32'h0, 8'hFF, 1'b0, 1'b0, 2'd0, 1'b0));
    send_word(mk(xfcu_pkg::FN_LAHF, 32'h0, 8'h00, 1'b0, 1'b0, 2'd0, 1'b0));
    send_word(mk(xfcu_pkg::FN_PUSHF, 32'h0, 8'h00, 1'b0, 1'b0, 2'd0, 1'b0));
    send_word(mk(xfcu_pkg::FN_PUSHFD, 32'h0, 8'h00, 1'b0, 1'b0, 2'd0, 1'b0));
    // IOPL 3 with IF and TF set
    send_word(mk(xfcu_pkg::FN_POPFD, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b0, 2'd0, 1'b0));
    send_word(mk(xfcu_pkg::FN_PUSHFD, 32'h0, 8'h00, 1'b0, 1'b0, 2'd0, 1'b0));
    send_word(mk(xfcu_pkg::FN_STI, 32'h0, 8'h00, 1'b1, 1'b1, 2'd3, 1'b1));
    send_word(mk(xfcu_pkg::FN_STI, 32'h0, 8'h00, 1'b1, 1'b1, 2'd3, 1'b0));
    send_word(mk(xfcu_pkg::FN_CLI, 32'h0, 8'h00, 1'b1, 1'b1, 2'd3, 1'b0));
    // back to IOPL 0
    send_word(mk(xfcu_pkg::FN_POPF, 32'h0, 8'h00, 1'b1, 1'b0, 2'd0, 1'b0));
    send_word(mk(xfcu_pkg::FN_PUSHF, 32'h0, 8'h00, 1'b1, 1'b1, 2'd3, 1'b1));
    send_word(mk(xfcu_pkg::FN_POPFD, 32'hFFFF_FFFF, 8'h00, 1'b1, 1'b1, 2'd3, 1'b1));
    send_word(mk(xfcu_pkg::FN_STI, 32'h0, 8'h00, 1'b1, 1'b1, 2'd3, 1'b1));
    send_word(mk(xfcu_pkg::FN_STI, 32'h0, 8'h00, 1'b1, 1'b0, 2'd3, 1'b0));
    send_word(mk(xfcu_pkg::FN_CLI, 32'h0, 8'h00, 1'b1, 1'b0, 2'd2, 1'b0));
    send_word(mk(xfcu_pkg::FN_POPFD, 32'hFFFF_FFFF, 8'h00, 1'b1, 1'b0, 2'd3, 1'b0));
    send_word(mk(xfcu_pkg::FN_STI, 32'h0, 8'h00, 1'b0, 1'b1, 2'd3, 1'b0));
    send_word(mk(xfcu_pkg::FN_SAHF, 32'h0, 8'h00, 1'b0, 1'b0, 2'd0, 1'b0));
    send_word(mk(FN_NONE_A, 32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b1, 2'd3, 1'b1));
    send_word(mk(FN_NONE_B, 32'h0, 8'h00, 1'b0, 1'b0, 2'd0, 1'b0));
    send_word(mk(FN_NONE_C, 32'h0, 8'h00, 1'b1, 1'b0, 2'd1, 1'b0));
  endtask

  // receiver: random stalls
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) board.check_word(m_axis_tdata);
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    for (int i = 0; i < N_RANDOM; i++) begin
      // switch at random between busy and calm stretches
      if (i % 150 == 0) quiet = ($urandom_range(0, 3) == 0);
      send_word(rand_item());
    end
    s_axis_tvalid <= 1'b0;
    quiet = 1'b1;
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (board.err_cnt == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("tb failed");
    $finish;
  end

endmodule
